>>> sv/pqms_pkg.sv
// ----------------------------------------------------------------------------
// pqms_pkg
// Shared types and constants for the max-scan priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package pqms_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VAL_W        = 32;
  localparam int PRI_W        = 16;
  localparam int OCC_W        = 5;
  localparam int ENTRY_W      = VAL_W + PRI_W;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_DEQUEUED = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic start;
    logic scan_step;
    logic shift_init;
    logic shift_step;
    logic commit;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic scan_done;
    logic shift_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> sv/pqms_ram.sv
// ----------------------------------------------------------------------------
// pqms_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pqms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> sv/pqms_ctrl.sv
// ----------------------------------------------------------------------------
// pqms_ctrl
// Sequencer: accept, scan for the maximum and close the gap on a dequeue, post.
// ----------------------------------------------------------------------------
`default_nettype none

module pqms_ctrl import pqms_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic in_operation,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_INIT,
    S_SHIFT,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          if (in_operation == OP_DEQ && !sts.empty) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_SHIFT_INIT;
        end
      end
      S_SHIFT_INIT: begin
        cmd.shift_init = 1'b1;
        state_nxt      = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (sts.shift_done) begin
          cmd.commit = 1'b1;
          state_nxt  = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/pqms_dp.sv
// ----------------------------------------------------------------------------
// pqms_dp
// Entry store, count, scan comparator, gap-closing shifter, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pqms_dp import pqms_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire cmd_t                    cmd,
  output sts_t                         sts,
  input  wire logic                    in_operation,
  input  wire logic signed [VAL_W-1:0] in_item_value,
  input  wire logic signed [PRI_W-1:0] in_item_priority,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [VAL_W-1:0]      out_value,
  output logic        [1:0]            out_status,
  output logic        [OCC_W-1:0]      out_occupancy
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [CW-1:0]           rd_idx_r, rd_idx_nxt;
  logic                    pend_r, pend_nxt;
  logic [CW-1:0]           pend_idx_r, pend_idx_nxt;
  logic [CW-1:0]           best_idx_r, best_idx_nxt;
  logic signed [PRI_W-1:0] best_pri_r, best_pri_nxt;
  logic signed [VAL_W-1:0] best_val_r, best_val_nxt;
  status_t                 res_status_r, res_status_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] out_value_r, out_value_nxt;
  logic [1:0]              out_status_r, out_status_nxt;
  logic [OCC_W-1:0]        out_occ_r, out_occ_nxt;

  logic                    full, empty, issue;
  logic [CW-1:0]           wr_idx;
  logic [CW+OCC_W-1:0]     occ_ext;
  logic                    ram_we, ram_re;
  logic [AW-1:0]           ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]      ram_wdata, ram_rdata;
  logic signed [PRI_W-1:0] rd_pri;
  logic signed [VAL_W-1:0] rd_val;

  pqms_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign full    = (cnt_r == CW'(CAPACITY));
  assign empty   = (cnt_r == '0);
  assign issue   = (rd_idx_r != cnt_r);
  assign wr_idx  = pend_idx_r - CW'(1);
  assign rd_pri  = $signed(ram_rdata[PRI_W-1:0]);
  assign rd_val  = $signed(ram_rdata[ENTRY_W-1:PRI_W]);
  assign occ_ext = {{OCC_W{1'b0}}, cnt_r};

  assign ram_re    = (cmd.scan_step || cmd.shift_step) && issue;
  assign ram_raddr = rd_idx_r[AW-1:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_r[AW-1:0];
    ram_wdata = {in_item_value, in_item_priority};
    if (cmd.start && in_operation == OP_ENQ && !full) begin
      ram_we = 1'b1;
    end else if (cmd.shift_step && pend_r) begin
      ram_we    = 1'b1;
      ram_waddr = wr_idx[AW-1:0];
      ram_wdata = ram_rdata;
    end
  end

  assign sts.full       = full;
  assign sts.empty      = empty;
  assign sts.scan_done  = pend_r && ((pend_idx_r + CW'(1)) == cnt_r);
  assign sts.shift_done = !issue && !pend_r;
  assign sts.out_free   = !out_valid_r || out_ready;

  always_comb begin
    cnt_nxt        = cnt_r;
    rd_idx_nxt     = rd_idx_r;
    pend_nxt       = pend_r;
    pend_idx_nxt   = pend_idx_r;
    best_idx_nxt   = best_idx_r;
    best_pri_nxt   = best_pri_r;
    best_val_nxt   = best_val_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_occ_nxt    = out_occ_r;

    if (cmd.start) begin
      rd_idx_nxt = '0;
      pend_nxt   = 1'b0;
      if (in_operation == OP_ENQ) begin
        if (full) begin
          res_status_nxt = ST_FULL;
        end else begin
          res_status_nxt = ST_ENQUEUED;
          cnt_nxt        = cnt_r + CW'(1);
        end
      end else begin
        res_status_nxt = empty ? ST_EMPTY : ST_DEQUEUED;
      end
    end

    if (cmd.scan_step || cmd.shift_step) begin
      if (issue) begin
        rd_idx_nxt = rd_idx_r + CW'(1);
      end
      pend_nxt     = issue;
      pend_idx_nxt = rd_idx_r;
    end

    if (cmd.scan_step && pend_r) begin
      if (pend_idx_r == '0 || rd_pri > best_pri_r) begin
        best_idx_nxt = pend_idx_r;
        best_pri_nxt = rd_pri;
        best_val_nxt = rd_val;
      end
    end

    if (cmd.shift_init) begin
      rd_idx_nxt = best_idx_r + CW'(1);
      pend_nxt   = 1'b0;
    end

    if (cmd.commit) begin
      cnt_nxt = cnt_r - CW'(1);
    end

    if (cmd.load_out) begin
      out_valid_nxt  = 1'b1;
      out_value_nxt  = (res_status_r == ST_DEQUEUED) ? best_val_r : '0;
      out_status_nxt = res_status_r;
      out_occ_nxt    = occ_ext[OCC_W-1:0];
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_idx_r     <= rd_idx_nxt;
    pend_idx_r   <= pend_idx_nxt;
    best_idx_r   <= best_idx_nxt;
    best_pri_r   <= best_pri_nxt;
    best_val_r   <= best_val_nxt;
    res_status_r <= res_status_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occ_r;

endmodule

`default_nettype wire

>>> sv/priority_queue_max_scan_top.sv
// ----------------------------------------------------------------------------
// priority_queue_max_scan_top
// Bounded priority queue held unsorted in arrival order; dequeue removes the
// highest-priority entry (earliest arrival on a tie).
//
//   channel | signals                                         | direction
//   --------+-------------------------------------------------+----------
//   in      | in_valid/in_ready, in_operation, in_item_value, | input
//           | in_item_priority                                |
//   out     | out_valid/out_ready, out_value, out_status,     | output
//           | out_occupancy                                   |
//
// Enqueue, full or empty: an accept state, then a post state.
// Dequeue of N held entries (k = removed slot from 0): accept, a scan over
// all N entries, a setup state, a shift that moves the entries after slot k
// down (none when k is the last slot), then post. The single read port of the
// entry RAM reads one entry per cycle in scan and shift.
// One item at a time; a new item is taken while a result waits at out, and the
// post cycle holds until out is free. Reset clears state, count, valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_queue_max_scan_top import pqms_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    in_operation,
  input  wire logic signed [VAL_W-1:0] in_item_value,
  input  wire logic signed [PRI_W-1:0] in_item_priority,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [VAL_W-1:0]      out_value,
  output logic        [1:0]            out_status,
  output logic        [OCC_W-1:0]      out_occupancy
);

  cmd_t cmd;
  sts_t sts;

  pqms_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_operation(in_operation),
    .in_ready    (in_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  pqms_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_operation    (in_operation),
    .in_item_value   (in_item_value),
    .in_item_priority(in_item_priority),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_value       (out_value),
    .out_status      (out_status),
    .out_occupancy   (out_occupancy)
  );

endmodule

`default_nettype wire

>>> sv/pqms_checker.sv
// ----------------------------------------------------------------------------
// pqms_checker
// Port-level checks on the priority queue's input and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

module pqms_checker import pqms_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic signed [VAL_W-1:0] out_value,
  input wire logic        [1:0]       out_status,
  input wire logic        [OCC_W-1:0] out_occupancy
);

  localparam logic [OCC_W-1:0] CAP_OCC = OCC_W'(CAPACITY % (1 << OCC_W));

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) &&
    $stable(out_status) && $stable(out_occupancy))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer in before result posted");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_occupancy == '0)
    else $error("empty status with nonzero occupancy");

  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_occupancy == CAP_OCC)
    else $error("full status with wrong occupancy");

  a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DEQUEUED |-> out_value == '0)
    else $error("nonzero value without a dequeue");

endmodule

bind priority_queue_max_scan_top pqms_checker #(
  .CAPACITY(CAPACITY)
) u_pqms_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_value    (out_value),
  .out_status   (out_status),
  .out_occupancy(out_occupancy)
);

`default_nettype wire

>>> tb/priority_queue_max_scan_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_queue_max_scan_top_test
// Self-checking bench for the max-scan priority queue. A local shadow of the
// queue, kept in arrival order, predicts value, status and occupancy for each
// transfer in. Results are checked in order as they leave. Covers empty and
// full cases, ties, field extremes, long output stalls and random traffic.
// ----------------------------------------------------------------------------

module priority_queue_max_scan_top_test;
  import pqms_pkg::*;

  localparam int CAP         = CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    status_t                 status;
    logic [OCC_W-1:0]        occupancy;
  } pq_result_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic                    in_operation;
  logic signed [VAL_W-1:0] in_item_value;
  logic signed [PRI_W-1:0] in_item_priority;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [VAL_W-1:0] out_value;
  logic [1:0]              out_status;
  logic [OCC_W-1:0]        out_occupancy;

  // shadow of the queue contents
  logic signed [VAL_W-1:0] held_value [CAP];
  logic signed [PRI_W-1:0] held_priority [CAP];
  int                      held_count;

  pq_result_t pending_results[$];
  pq_result_t oldest_result;
  int         mismatch_count;
  int         cycle_count;
  int         hold_off_cycles;
  bit         idle_enabled;

  priority_queue_max_scan_top #(
    .CAPACITY(CAP)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_item_value   (in_item_value),
    .in_item_priority(in_item_priority),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_value       (out_value),
    .out_status      (out_status),
    .out_occupancy   (out_occupancy)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("priority_queue_max_scan_top_test: done, errors");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  task automatic predict_operation(input logic op, input logic signed [VAL_W-1:0] val,
                                   input logic signed [PRI_W-1:0] pri);
    pq_result_t r;
    int         best;
    r.value = '0;
    if (op == OP_ENQ) begin
      if (held_count >= CAP) begin
        r.status = ST_FULL;
      end else begin
        held_value[held_count]    = val;
        held_priority[held_count] = pri;
        held_count++;
        r.status = ST_ENQUEUED;
      end
    end else if (held_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      best = 0;
      for (int i = 1; i < held_count; i++) begin
        if (held_priority[i] > held_priority[best]) best = i;
      end
      r.value = held_value[best];
      for (int i = best; i < held_count - 1; i++) begin
        held_value[i]    = held_value[i + 1];
        held_priority[i] = held_priority[i + 1];
      end
      held_count--;
      r.status = ST_DEQUEUED;
    end
    r.occupancy = OCC_W'(held_count);
    pending_results.push_back(r);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, status", out_status, -1);
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_value !== oldest_result.value)
          report_mismatch("out_value", out_value, oldest_result.value);
        if (out_status !== oldest_result.status)
          report_mismatch("out_status", out_status, oldest_result.status);
        if (out_occupancy !== oldest_result.occupancy)
          report_mismatch("out_occupancy", out_occupancy, oldest_result.occupancy);
      end
    end
  end

  // receiver: random stalls, plus long hold-offs on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles != 0) begin
        out_ready = 1'b0;
        for (int n = 0; n < hold_off_cycles; n++) @(negedge clk);
        hold_off_cycles = 0;
        out_ready = 1'b1;
      end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        out_ready = 1'b1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_operation(input logic op, input logic signed [VAL_W-1:0] val,
                                input logic signed [PRI_W-1:0] pri);
    if (idle_enabled && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_operation     = op;
    in_item_value    = val;
    in_item_priority = pri;
    in_valid         = 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_operation(op, val, pri);
    @(negedge clk);
  endtask

  task automatic wait_results_drained();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [PRI_W-1:0] pick_priority();
    case ($urandom_range(0, 3))
      0:       return PRI_W'($urandom_range(0, 6)) - 16'sd3;
      1: begin
        case ($urandom_range(0, 3))
          0:       return 16'sh8000;
          1:       return 16'sh7fff;
          2:       return 16'sh0000;
          default: return -16'sd1;
        endcase
      end
      default: return PRI_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic test_empty_dequeue();
    send_operation(OP_DEQ, $urandom, pick_priority());
  endtask

  // ties on the top priority must come out in arrival order
  task automatic test_field_extremes();
    send_operation(OP_ENQ, 32'sh7fffffff, 16'sh8000);
    send_operation(OP_ENQ, 32'sh80000000, 16'sh7fff);
    send_operation(OP_ENQ, 32'sh00000000, -16'sd1);
    send_operation(OP_ENQ, 32'sd5,        16'sh7fff);
    repeat (4) send_operation(OP_DEQ, 32'shffffffff, 16'shffff);
  endtask

  task automatic test_fill_to_full();
    repeat (CAP) send_operation(OP_ENQ, $urandom, PRI_W'($urandom_range(0, 3)));
    send_operation(OP_ENQ, $urandom, 16'sh7fff);
    send_operation(OP_DEQ, $urandom, pick_priority());
  endtask

  task automatic test_output_hold_off();
    hold_off_cycles = 150;
    repeat (24) send_operation(1'($urandom_range(0, 1)), $urandom, pick_priority());
    wait_results_drained();
  endtask

  task automatic test_random_mix(input int count);
    int enq_bias;
    enq_bias = 50;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       enq_bias = 25;
          1:       enq_bias = 50;
          default: enq_bias = 80;
        endcase
      end
      if (n % 150 == 149) wait_results_drained();
      send_operation(($urandom_range(0, 99) < enq_bias) ? OP_ENQ : OP_DEQ,
                     $urandom, pick_priority());
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_operation     = OP_ENQ;
    in_item_value    = '0;
    in_item_priority = '0;
    held_count       = 0;
    mismatch_count   = 0;
    cycle_count      = 0;
    hold_off_cycles  = 0;
    idle_enabled     = 1'b1;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_empty_dequeue();
    test_field_extremes();
    test_fill_to_full();
    test_output_hold_off();
    test_random_mix(650);
    idle_enabled = 1'b0;
    test_random_mix(150);

    wait_results_drained();
    repeat (2 * CAP + 8) @(negedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("priority_queue_max_scan_top_test: done, clean");
    end else begin
      $display("priority_queue_max_scan_top_test: done, errors");
    end
    $finish;
  end

endmodule
